// File: rtl/dpc_pkg.sv
// Shared types, codes and constants of the DDS parameter converter.
package dpc_pkg;

    // Default tuning word width
    localparam int DPC_TUNING_WORD_BITS = 32;

    // Depth of the queue between front and back
    localparam int DPC_QUEUE_DEPTH = 4;

    // Divisor width: four times a 32-bit rate
    localparam int DPC_DEN_BITS = 34;

    // Register reset values
    localparam logic [30:0] DPC_SYSCLK_RESET = 31'd1000000000;
    localparam logic [30:0] DPC_MAXFREQ_RESET = 31'd400000000;
    localparam logic [13:0] DPC_MAXAMP_RESET = 14'd16383;

    // Conversion constants
    localparam logic [6:0] DPC_PCT_FULL = 7'd100;
    localparam int DPC_PCT_ROUND = 50;
    localparam int DPC_DEG_DIV = 360;
    localparam int DPC_DEG_ROUND = 180;
    localparam logic [15:0] DPC_STEP_MAX = 16'hFFFF;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] DPC_REG_SYSCLK = 2'd0;
    localparam logic [1:0] DPC_REG_MAXFREQ = 2'd1;
    localparam logic [1:0] DPC_REG_MAXAMP = 2'd2;

    typedef enum logic [1:0] {
        OP_FREQ = 2'd0,
        OP_RATE = 2'd1,
        OP_PCT  = 2'd2,
        OP_DEG  = 2'd3
    } dpc_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CLAMPED  = 2'd1,
        ST_REJECTED = 2'd2
    } dpc_status_t;

    // Classification that travels with each request
    typedef struct packed {
        dpc_op_t op;
        logic    reject;
        logic    clamp;
    } dpc_meta_t;

endpackage

// File: rtl/dpc_front.sv
// Front end: classify a request and build dividend and divisor.
module dpc_front
    import dpc_pkg::*;
#(
    parameter int TUNING_WORD_BITS = DPC_TUNING_WORD_BITS
) (
    input  logic [1:0]                     req_type,
    input  logic [31:0]                    operand,
    input  logic [30:0]                    sysclk,
    input  logic [30:0]                    maxfreq,
    input  logic [13:0]                    maxamp,
    output dpc_meta_t                      meta,
    output logic [TUNING_WORD_BITS+31:0]   num,
    output logic [DPC_DEN_BITS-1:0]        den
);

    localparam int NW = TUNING_WORD_BITS + 32;

    logic [6:0]  pct;
    logic [20:0] pct_prod;

    // Clamp percent and scale
    always_comb
    begin
        pct = (operand[7:0] > 8'(DPC_PCT_FULL)) ? DPC_PCT_FULL : operand[6:0];
        pct_prod = 21'(pct) * 21'(maxamp);
    end

    // Build the division for the selected conversion
    always_comb
    begin
        meta.op = dpc_op_t'(req_type);
        meta.reject = 1'b0;
        meta.clamp = 1'b0;
        num = '0;
        den = DPC_DEN_BITS'(1);
        unique case (dpc_op_t'(req_type))
            OP_FREQ:
            begin
                if (operand > 32'(maxfreq) || sysclk == 31'd0)
                begin
                    meta.reject = 1'b1;
                end
                else
                begin
                    num = (NW'(operand[30:0]) << TUNING_WORD_BITS) + NW'(sysclk[30:1]);
                    den = DPC_DEN_BITS'(sysclk);
                end
            end
            OP_RATE:
            begin
                if (operand == 32'd0)
                begin
                    meta.reject = 1'b1;
                end
                else
                begin
                    num = NW'(sysclk) + NW'({operand, 1'b0});
                    den = {operand, 2'b00};
                end
            end
            OP_PCT:
            begin
                meta.clamp = (operand[7:0] > 8'(DPC_PCT_FULL));
                num = NW'(pct_prod) + NW'(DPC_PCT_ROUND);
                den = DPC_DEN_BITS'(DPC_PCT_FULL);
            end
            OP_DEG:
            begin
                // low 16 bits of the quotient equal the reduced phase word
                num = NW'({operand[15:0], 16'd0}) + NW'(DPC_DEG_ROUND);
                den = DPC_DEN_BITS'(DPC_DEG_DIV);
            end
            default:
            begin
                meta.reject = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/dpc_fifo.sv
// Small queue between front and back.
module dpc_fifo
    import dpc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DPC_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// File: rtl/dpc_back.sv
// Back end: pipelined restoring divider and result formatting.
module dpc_back
    import dpc_pkg::*;
#(
    parameter int TUNING_WORD_BITS = DPC_TUNING_WORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  dpc_meta_t                      q_meta,
    input  logic [TUNING_WORD_BITS+31:0]   q_num,
    input  logic [DPC_DEN_BITS-1:0]        q_den,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    out_value,
    output logic [1:0]                     out_status
);

    localparam int NW = TUNING_WORD_BITS + 32;
    localparam int DW = DPC_DEN_BITS;
    localparam int WB = (TUNING_WORD_BITS < 32) ? TUNING_WORD_BITS : 32;

    logic                stg_vld_reg  [0:NW];
    dpc_meta_t           stg_meta_reg [0:NW];
    logic [NW-1:0]       stg_num_reg  [0:NW];
    logic [DW-1:0]       stg_rem_reg  [0:NW];
    logic [DW-1:0]       stg_den_reg  [0:NW];

    logic [DW:0]         trial    [0:NW-1];
    logic                ge       [0:NW-1];
    logic [DW-1:0]       rem_next [0:NW-1];
    logic [NW-1:0]       num_next [0:NW-1];

    logic                advance;
    logic                out_valid_reg;
    logic [31:0]         out_value_reg;
    dpc_status_t         out_status_reg;
    logic [31:0]         value_next;
    dpc_status_t         status_next;
    logic [NW-1:0]       quo;

    assign advance = !out_valid_reg || out_ready;
    assign q_pop = advance && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_status = out_status_reg;

    // One quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < NW; k++)
        begin
            trial[k] = {stg_rem_reg[k], stg_num_reg[k][NW-1]};
            ge[k] = (trial[k] >= {1'b0, stg_den_reg[k]});
            rem_next[k] = ge[k] ? DW'(trial[k] - {1'b0, stg_den_reg[k]}) : trial[k][DW-1:0];
            num_next[k] = {stg_num_reg[k][NW-2:0], ge[k]};
        end
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NW; k++)
            begin
                stg_vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            stg_vld_reg[0] <= !q_empty;
            for (int k = 0; k < NW; k++)
            begin
                stg_vld_reg[k+1] <= stg_vld_reg[k];
            end
        end
    end

    // Advance stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg_meta_reg[0] <= q_meta;
            stg_num_reg[0] <= q_num;
            stg_rem_reg[0] <= '0;
            stg_den_reg[0] <= q_den;
            for (int k = 0; k < NW; k++)
            begin
                stg_meta_reg[k+1] <= stg_meta_reg[k];
                stg_num_reg[k+1] <= num_next[k];
                stg_rem_reg[k+1] <= rem_next[k];
                stg_den_reg[k+1] <= stg_den_reg[k];
            end
        end
    end

    // Format the quotient for the conversion
    always_comb
    begin
        quo = stg_num_reg[NW];
        value_next = '0;
        status_next = ST_OK;
        if (stg_meta_reg[NW].reject)
        begin
            status_next = ST_REJECTED;
        end
        else
        begin
            unique case (stg_meta_reg[NW].op)
                OP_FREQ:
                begin
                    if (|quo[NW-1:WB])
                    begin
                        value_next = 32'({WB{1'b1}});
                        status_next = ST_CLAMPED;
                    end
                    else
                    begin
                        value_next = 32'(quo[WB-1:0]);
                    end
                end
                OP_RATE:
                begin
                    if (quo == '0)
                    begin
                        value_next = 32'd1;
                        status_next = ST_CLAMPED;
                    end
                    else if (|quo[NW-1:16])
                    begin
                        value_next = 32'(DPC_STEP_MAX);
                        status_next = ST_CLAMPED;
                    end
                    else
                    begin
                        value_next = 32'(quo[15:0]);
                    end
                end
                OP_PCT:
                begin
                    value_next = 32'(quo[13:0]);
                    status_next = stg_meta_reg[NW].clamp ? ST_CLAMPED : ST_OK;
                end
                OP_DEG:
                begin
                    value_next = 32'(quo[15:0]);
                end
                default:
                begin
                    value_next = '0;
                end
            endcase
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stg_vld_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg <= value_next;
            out_status_reg <= status_next;
        end
    end

endmodule

// File: rtl/dds_parameter_converter_unit.sv
// Top level of the DDS parameter converter with APB registers.
// A transaction passes through the queue, one divider stage per quotient bit and the
// output register. Throughput: one transaction per cycle unless m_axis_tready stalls
// the output; the divider is fully pipelined.
// Reset: asynchronous, active low; registers return to their defaults, queue and
// pipeline empty.
module dds_parameter_converter_unit
    import dpc_pkg::*;
#(
    parameter int TUNING_WORD_BITS = DPC_TUNING_WORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_value, [33:32] conv_status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW = TUNING_WORD_BITS + 32;
    localparam int QW = $bits(dpc_meta_t) + NW + DPC_DEN_BITS;

    logic [30:0]              sysclk_reg;
    logic [30:0]              maxfreq_reg;
    logic [13:0]              maxamp_reg;

    dpc_meta_t                f_meta;
    logic [NW-1:0]            f_num;
    logic [DPC_DEN_BITS-1:0]  f_den;
    logic                     q_full;
    logic                     q_empty;
    logic                     q_pop;
    logic [QW-1:0]            q_data;
    dpc_meta_t                q_meta;
    logic [NW-1:0]            q_num;
    logic [DPC_DEN_BITS-1:0]  q_den;
    logic [31:0]              res_value;
    logic [1:0]               res_status;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sysclk_reg <= DPC_SYSCLK_RESET;
            maxfreq_reg <= DPC_MAXFREQ_RESET;
            maxamp_reg <= DPC_MAXAMP_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                DPC_REG_SYSCLK:  sysclk_reg <= pwdata[30:0];
                DPC_REG_MAXFREQ: maxfreq_reg <= pwdata[30:0];
                DPC_REG_MAXAMP:  maxamp_reg <= pwdata[13:0];
                default:         ;
            endcase
        end
    end

    // Read back registers
    always_comb
    begin
        unique case (paddr[3:2])
            DPC_REG_SYSCLK:  prdata = 32'(sysclk_reg);
            DPC_REG_MAXFREQ: prdata = 32'(maxfreq_reg);
            DPC_REG_MAXAMP:  prdata = 32'(maxamp_reg);
            default:         prdata = '0;
        endcase
    end

    dpc_front #(
        .TUNING_WORD_BITS(TUNING_WORD_BITS)
    ) u_front (
        .req_type(s_axis_tuser),
        .operand(s_axis_tdata),
        .sysclk(sysclk_reg),
        .maxfreq(maxfreq_reg),
        .maxamp(maxamp_reg),
        .meta(f_meta),
        .num(f_num),
        .den(f_den)
    );

    assign s_axis_tready = !q_full;

    dpc_fifo #(
        .WIDTH(QW),
        .DEPTH(DPC_QUEUE_DEPTH)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(s_axis_tvalid),
        .push_data({f_meta, f_num, f_den}),
        .full(q_full),
        .pop(q_pop),
        .pop_data(q_data),
        .empty(q_empty)
    );

    assign {q_meta, q_num, q_den} = q_data;

    dpc_back #(
        .TUNING_WORD_BITS(TUNING_WORD_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_meta(q_meta),
        .q_num(q_num),
        .q_den(q_den),
        .q_pop(q_pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_value(res_value),
        .out_status(res_status)
    );

    assign m_axis_tdata = {6'd0, res_status, res_value};

`ifndef SYNTHESIS
    // A rejected transaction carries a zero result
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[33:32] == ST_REJECTED) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("rejected result not zero");

    // Status code is never the unused value
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:32] != 2'd3))
        else $error("illegal status code");

    // Queue pops only with data present
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");
`endif

endmodule
